>>> rtl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared constants, types and helpers of the directed cycle detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int DEPTH_W   = NODE_W + 1;
    localparam int CNT_W     = 7;

    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_CHECK = 1'b1;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

    typedef logic [MAX_NODES-1:0] t_row;
    typedef logic [NODE_W-1:0]    t_node;

    // Write request into the adjacency store: set bit col of row row.
    typedef struct packed {
        logic  en;
        t_node row;
        t_node col;
    } t_adj_wr;

    // Status from the walk sequencer back to the top level.
    typedef struct packed {
        logic done;
        logic found;
    } t_walk_stat;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic t_node lowest_set(input t_row v);
        t_node idx;
        idx = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = t_node'(k);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/dcd_adj_mem.sv
// ----------------------------------------------------------------------------
// dcd_adj_mem
// Adjacency bit matrix, one row per source node, with a valid flag per row
// so that reset empties the graph at once.
// ----------------------------------------------------------------------------
module dcd_adj_mem
    import dcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_adj_wr i_wr,
    input  t_node   i_rd_row,
    output t_row    o_rd_data
);

    t_row                 r_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;
    t_row                 w_onehot;

    assign w_onehot = t_row'(1) << i_wr.col;

    // A row that was never written holds garbage, so its first write stores
    // the whole row and later writes set single bits.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (r_row_vld[i_wr.row]) begin
                r_mem[i_wr.row][i_wr.col] <= 1'b1;
            end else begin
                r_mem[i_wr.row] <= w_onehot;
            end
        end
        r_rd_data <= r_mem[i_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_row_vld[i_wr.row] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> rtl/dcd_walk.sv
// ----------------------------------------------------------------------------
// dcd_walk
// Depth-first walk sequencer: node stack, visited and on-path marks, and one
// shared lowest-bit unit that picks the next unvisited neighbor.
// ----------------------------------------------------------------------------
module dcd_walk
    import dcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_row       i_lim_mask,
    input  t_row       i_row_data,
    output t_node      o_rd_row,
    output t_walk_stat o_stat
);

    typedef enum logic [1:0] {
        W_IDLE,
        W_FETCH,
        W_EVAL,
        W_POP
    } t_wstate;

    t_wstate            r_state, n_state;
    t_row               r_visited, n_visited;
    t_row               r_on_path, n_on_path;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    t_node              r_top, n_top;
    logic               r_found, n_found;
    logic               r_done, n_done;

    t_node              r_stack [MAX_NODES];
    t_node              r_stack_q;
    logic               w_push_en;
    t_node              w_push_idx;
    t_node              w_push_val;
    t_node              w_pop_idx;

    t_row               w_nbrs;
    t_row               w_cand;
    t_node              w_next;
    t_row               w_next_bit;
    logic               w_back;

    assign w_nbrs     = i_row_data & i_lim_mask;
    assign w_cand     = w_nbrs & ~r_visited;
    assign w_next     = lowest_set(w_cand);
    assign w_next_bit = t_row'(1) << w_next;
    // Any neighbor on the current path, the node itself included, closes a
    // cycle; the path is the same every time this node is at the top.
    assign w_back     = |(w_nbrs & r_on_path);
    // Entry below the current top, read ahead for a pop.
    assign w_pop_idx  = r_depth[NODE_W-1:0] - t_node'(2);

    always_comb begin
        n_state    = r_state;
        n_visited  = r_visited;
        n_on_path  = r_on_path;
        n_depth    = r_depth;
        n_top      = r_top;
        n_found    = r_found;
        n_done     = 1'b0;
        w_push_en  = 1'b0;
        w_push_idx = r_depth[NODE_W-1:0];
        w_push_val = w_next;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_visited  = t_row'(1);
                    n_on_path  = t_row'(1);
                    n_depth    = DEPTH_W'(1);
                    n_top      = '0;
                    n_found    = 1'b0;
                    w_push_en  = 1'b1;
                    w_push_idx = '0;
                    w_push_val = '0;
                    n_state    = W_FETCH;
                end
            end
            W_FETCH: begin
                n_state = W_EVAL;
            end
            W_EVAL: begin
                n_found = r_found | w_back;
                if (|w_cand) begin
                    n_visited = r_visited | w_next_bit;
                    n_on_path = r_on_path | w_next_bit;
                    w_push_en = 1'b1;
                    n_depth   = r_depth + DEPTH_W'(1);
                    n_top     = w_next;
                    n_state   = W_FETCH;
                end else begin
                    n_on_path = r_on_path & ~(t_row'(1) << r_top);
                    n_depth   = r_depth - DEPTH_W'(1);
                    if (r_depth == DEPTH_W'(1)) begin
                        n_done  = 1'b1;
                        n_state = W_IDLE;
                    end else begin
                        n_state = W_POP;
                    end
                end
            end
            W_POP: begin
                n_top   = r_stack_q;
                n_state = W_FETCH;
            end
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= W_IDLE;
            r_visited <= '0;
            r_on_path <= '0;
            r_depth   <= '0;
            r_top     <= '0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_on_path <= n_on_path;
            r_depth   <= n_depth;
            r_top     <= n_top;
            r_found   <= n_found;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_en) begin
            r_stack[w_push_idx] <= w_push_val;
        end
        r_stack_q <= r_stack[w_pop_idx];
    end

    assign o_rd_row     = r_top;
    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;

endmodule

>>> rtl/directed_cycle_detect_dfs_unit.sv
// ----------------------------------------------------------------------------
// directed_cycle_detect_dfs_unit
// Directed graph cycle detector: edge loads into an adjacency matrix and a
// depth-first cycle check from node 0.
// ----------------------------------------------------------------------------
// Edge load requests are accepted back to back. During a check the input
// is not ready; the walk fetches one adjacency row per step from the
// single read port of the matrix, and the result goes to a registered
// output that is held until it is taken.
// Synchronous active-low reset empties the graph at once (row valid flags)
// and sets node_count to 64.
module directed_cycle_detect_dfs_unit
    import dcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,    // node_count
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,   // [5:0] from_node, [11:6] to_node
    input  logic             i_s_axis_tuser,   // action
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata    // [0] cycle_found
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_WALK,
        T_PUSH
    } t_tstate;

    t_tstate          r_state;
    logic [CNT_W-1:0] r_lim;
    t_row             r_lim_mask;
    logic             r_hold_found;
    logic             r_out_valid;
    logic             r_out_found;

    logic [CNT_W-1:0] w_cfg_lim;
    t_row             w_cfg_mask;
    logic             w_in_acc;
    logic             w_out_acc;
    t_node            w_from;
    t_node            w_to;
    logic             w_start;
    t_adj_wr          w_adj_wr;
    t_node            w_rd_row;
    t_row             w_row_data;
    t_walk_stat       w_stat;

    assign w_from    = i_s_axis_tdata[NODE_W-1:0];
    assign w_to      = i_s_axis_tdata[2*NODE_W-1:NODE_W];
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_out_valid && i_m_axis_tready;

    assign w_cfg_lim  = (i_cfg_wr_data > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                              : i_cfg_wr_data;
    assign w_cfg_mask = (w_cfg_lim >= CNT_W'(MAX_NODES)) ? '1
                        : ((t_row'(1) << w_cfg_lim[NODE_W-1:0]) - t_row'(1));

    assign w_adj_wr.en  = w_in_acc && (i_s_axis_tuser == ACT_LOAD)
                          && (CNT_W'(w_from) < r_lim) && (CNT_W'(w_to) < r_lim);
    assign w_adj_wr.row = w_from;
    assign w_adj_wr.col = w_to;

    assign w_start = w_in_acc && (i_s_axis_tuser == ACT_CHECK) && (r_lim != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_lim        <= NODE_COUNT_RST;
            r_lim_mask   <= '1;
            r_hold_found <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_found  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lim      <= w_cfg_lim;
                r_lim_mask <= w_cfg_mask;
            end
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (w_in_acc && (i_s_axis_tuser == ACT_CHECK)) begin
                        // With no nodes in use the walk is skipped.
                        r_hold_found <= 1'b0;
                        r_state      <= w_start ? T_WALK : T_PUSH;
                    end
                end
                T_WALK: begin
                    if (w_stat.done) begin
                        r_hold_found <= w_stat.found;
                        r_state      <= T_PUSH;
                    end
                end
                T_PUSH: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_hold_found;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    dcd_adj_mem u_adj_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_adj_wr),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_row_data)
    );

    dcd_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_lim_mask (r_lim_mask),
        .i_row_data (w_row_data),
        .o_rd_row   (w_rd_row),
        .o_stat     (w_stat)
    );

    assign o_s_axis_tready = (r_state == T_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_found};

    a_check_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_s_axis_tuser == ACT_CHECK)) |=> !o_s_axis_tready)
        else $error("input still ready after a check request");

    a_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == T_WALK))
        else $error("walk finished outside of a check");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == T_PUSH) && !r_out_valid) |=> (r_out_valid && o_s_axis_tready))
        else $error("check result not placed in the output register");

endmodule
